### hdl/indexed_shift_list_core_macros.svh
// Assertion macros for the indexed shift list core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef INDEXED_SHIFT_LIST_CORE_MACROS_SVH
`define INDEXED_SHIFT_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/isl_pkg.sv
// Shared types and constants for the indexed shift list core.
// No dependencies; used by isl_front, isl_back and the top level.
package isl_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int POS_W      = 5;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_REMOVE = 3'd3;
	localparam logic [2:0] CMD_POP    = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_INSERT,
		OP_READ,
		OP_REMOVE,
		OP_POP,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0]       command;
		logic [POS_W-1:0] position;
		logic [31:0]      data_in;
	} req_t;

	typedef struct packed {
		logic [31:0]      data_out;
		status_t          status;
		logic [4:0]       count_out;
	} rsp_t;

	typedef struct packed {
		op_t                   op;
		logic [POS_W-1:0]      position;
		logic [DATA_WIDTH-1:0] data;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

### hdl/isl_front.sv
// Front part: accepts request beats, decodes the command and queues the item.
// Depends on isl_pkg.
module isl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  isl_pkg::req_t        req,
	output isl_pkg::queue_head_t head,
	input  logic                 pop
);

	isl_pkg::item_t                  entry_q [isl_pkg::QUEUE_DEPTH];
	logic [isl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [isl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [isl_pkg::QCNT_W-1:0]      fill_q;
	isl_pkg::item_t                  decoded;
	logic                            push;

	always_comb begin
		decoded.position = req.position;
		decoded.data     = req.data_in[isl_pkg::DATA_WIDTH-1:0];
		case (req.command)
			isl_pkg::CMD_APPEND: decoded.op = isl_pkg::OP_APPEND;
			isl_pkg::CMD_INSERT: decoded.op = isl_pkg::OP_INSERT;
			isl_pkg::CMD_READ:   decoded.op = isl_pkg::OP_READ;
			isl_pkg::CMD_REMOVE: decoded.op = isl_pkg::OP_REMOVE;
			isl_pkg::CMD_POP:    decoded.op = isl_pkg::OP_POP;
			default:             decoded.op = isl_pkg::OP_NOP;
		endcase
	end

	assign req_stall  = (fill_q == isl_pkg::QCNT_W'(isl_pkg::QUEUE_DEPTH));
	assign push       = req_valid && !req_stall;
	assign head.valid = (fill_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### hdl/isl_back.sv
// Back part: shift-line element store, count, status and the response register.
// Depends on isl_pkg; takes items from the queue in isl_front.
module isl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  isl_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output isl_pkg::rsp_t        rsp
);

	logic [isl_pkg::DATA_WIDTH-1:0] cells_q [isl_pkg::CAPACITY];
	logic [isl_pkg::CNT_W-1:0]      count_q;
	logic                           rsp_valid_q;
	isl_pkg::rsp_t                  rsp_q;

	logic [isl_pkg::CMP_W-1:0]      cnt_e;
	logic [isl_pkg::CMP_W-1:0]      pos_e;
	logic [isl_pkg::CMP_W-1:0]      ins_pos;
	logic [isl_pkg::IDX_W-1:0]      rd_idx;
	logic [isl_pkg::DATA_WIDTH-1:0] rd_data;
	logic                           is_full;
	logic                           do_ins;
	logic                           do_rem;
	logic                           do_dec;
	logic                           give_data;
	isl_pkg::status_t               status;
	logic [isl_pkg::CNT_W-1:0]      count_nxt;

	assign pop = head.valid && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		cnt_e     = isl_pkg::CMP_W'(count_q);
		pos_e     = isl_pkg::CMP_W'(head.item.position);
		is_full   = (count_q >= isl_pkg::CNT_W'(isl_pkg::CAPACITY));
		ins_pos   = (head.item.op == isl_pkg::OP_APPEND) ? cnt_e : pos_e;
		rd_idx    = (head.item.op == isl_pkg::OP_POP)
			? isl_pkg::IDX_W'(count_q - 1'b1)
			: isl_pkg::IDX_W'(head.item.position);
		rd_data   = cells_q[rd_idx];
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		do_dec    = 1'b0;
		give_data = 1'b0;
		status    = isl_pkg::ST_OK;
		case (head.item.op)
			isl_pkg::OP_APPEND: begin
				if (is_full) status = isl_pkg::ST_FULL;
				else         do_ins = 1'b1;
			end
			isl_pkg::OP_INSERT: begin
				if (pos_e > cnt_e) status = isl_pkg::ST_INDEX;
				else if (is_full)  status = isl_pkg::ST_FULL;
				else               do_ins = 1'b1;
			end
			isl_pkg::OP_READ: begin
				if (pos_e >= cnt_e) status    = isl_pkg::ST_INDEX;
				else                give_data = 1'b1;
			end
			isl_pkg::OP_REMOVE: begin
				if (pos_e >= cnt_e) begin
					status = isl_pkg::ST_INDEX;
				end else begin
					give_data = 1'b1;
					do_rem    = 1'b1;
					do_dec    = 1'b1;
				end
			end
			isl_pkg::OP_POP: begin
				if (count_q == '0) begin
					status = isl_pkg::ST_EMPTY;
				end else begin
					give_data = 1'b1;
					do_dec    = 1'b1;
				end
			end
			default: status = isl_pkg::ST_OK;
		endcase
		count_nxt = count_q;
		if (do_ins)      count_nxt = count_q + 1'b1;
		else if (do_dec) count_nxt = count_q - 1'b1;
	end

	for (genvar g = 0; g < isl_pkg::CAPACITY; g++) begin : g_cell
		logic [isl_pkg::DATA_WIDTH-1:0] up_src;
		logic [isl_pkg::DATA_WIDTH-1:0] dn_src;
		if (g == 0) begin : g_first
			assign up_src = cells_q[g];
		end else begin : g_up
			assign up_src = cells_q[g-1];
		end
		if (g == isl_pkg::CAPACITY - 1) begin : g_last
			assign dn_src = cells_q[g];
		end else begin : g_dn
			assign dn_src = cells_q[g+1];
		end
		always_ff @(posedge clk) begin
			if (pop && do_ins) begin
				if (isl_pkg::CMP_W'(g) == ins_pos) begin
					cells_q[g] <= head.item.data;
				end else if (isl_pkg::CMP_W'(g) > ins_pos) begin
					cells_q[g] <= up_src;
				end
			end else if (pop && do_rem) begin
				if (isl_pkg::CMP_W'(g) >= pos_e) begin
					cells_q[g] <= dn_src;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q.data_out  <= give_data ? 32'(rd_data) : '0;
			rsp_q.status    <= status;
			rsp_q.count_out <= 5'(count_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q <= count_nxt;
			end
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hdl/indexed_shift_list_core.sv
// Indexed shift list core: top level joining the request queue and the shift-line back end.
// Depends on isl_pkg, isl_front, isl_back and indexed_shift_list_core_macros.svh.
// Each request beat yields exactly one response beat carrying the element (or zero), a
// status and the element count afterwards. A request enters a two-entry queue; the back end
// takes one queued item per cycle unless a stalled response holds it back, and finishes it
// in that cycle, as every stored cell loads from its neighbor in parallel for insert and
// remove. An accepted request is queued; its response is registered when the item is taken.
`include "indexed_shift_list_core_macros.svh"

module indexed_shift_list_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  isl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output isl_pkg::rsp_t rsp
);

	isl_pkg::queue_head_t head;
	logic                 pop;

	isl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	isl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`ISL_ASSERT_NOW(a_count_bound, rsp_valid, rsp.count_out <= 5'(isl_pkg::CAPACITY), "count above capacity")
	`ISL_ASSERT_NOW(a_full_count, rsp_valid && rsp.status == isl_pkg::ST_FULL, rsp.count_out == 5'(isl_pkg::CAPACITY), "full status with room left")
	`ISL_ASSERT_NOW(a_empty_zero, rsp_valid && rsp.status == isl_pkg::ST_EMPTY, rsp.count_out == '0 && rsp.data_out == '0, "empty status with data or count")
	`ISL_ASSERT_NEXT(a_pop_shows, pop, rsp_valid, "taken item gave no response")

endmodule

### tb/isl_checker.sv
// Checker for the indexed shift list core: watches the request and response channels,
// keeps its own copy of the list and compares every response beat with its prediction.
// Depends on isl_pkg for the beat types, command codes and status codes.
module isl_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  isl_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  isl_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import isl_pkg::*;

	logic [DATA_WIDTH-1:0] cells [CAPACITY];
	int unsigned           fill;
	rsp_t                  wanted_rsp_q[$];
	int                    mism;

	function automatic rsp_t apply_request(input req_t r);
		rsp_t        res;
		int unsigned p;
		res.data_out = '0;
		res.status   = ST_OK;
		p            = r.position;
		case (r.command)
			CMD_APPEND: begin
				if (fill >= CAPACITY) res.status = ST_FULL;
				else begin
					cells[fill] = r.data_in;
					fill++;
				end
			end
			CMD_INSERT: begin
				if (p > fill) res.status = ST_INDEX;
				else if (fill >= CAPACITY) res.status = ST_FULL;
				else begin
					for (int i = fill; i > p; i--) cells[i] = cells[i-1];
					cells[p] = r.data_in;
					fill++;
				end
			end
			CMD_READ: begin
				if (p >= fill) res.status = ST_INDEX;
				else res.data_out = cells[p];
			end
			CMD_REMOVE: begin
				if (p >= fill) res.status = ST_INDEX;
				else begin
					res.data_out = cells[p];
					for (int i = p + 1; i < fill; i++) cells[i-1] = cells[i];
					fill--;
				end
			end
			CMD_POP: begin
				if (fill == 0) res.status = ST_EMPTY;
				else begin
					fill--;
					res.data_out = cells[fill];
				end
			end
			default: ;
		endcase
		res.count_out = 5'(fill);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			fill = 0;
			wanted_rsp_q.delete();
			mism = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (req_valid && !req_stall) wanted_rsp_q.push_back(apply_request(req));
			if (rsp_valid && !rsp_stall) begin
				if (wanted_rsp_q.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected response beat: data_out=%h status=%0d count_out=%0d",
							rsp.data_out, rsp.status, rsp.count_out);
				end else begin
					want = wanted_rsp_q.pop_front();
					if (rsp.data_out !== want.data_out || rsp.status !== want.status ||
							rsp.count_out !== want.count_out) begin
						mism++;
						if (mism <= 10)
							$display("response mismatch: data_out %h/%h status %0d/%0d count_out %0d/%0d (expected/actual)",
								want.data_out, rsp.data_out, want.status, rsp.status,
								want.count_out, rsp.count_out);
					end
				end
			end
			errors  <= mism;
			pending <= wanted_rsp_q.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the indexed shift list core: clock, reset, request stimulus,
// response stalls and the verdict. Depends on isl_pkg, indexed_shift_list_core and isl_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import isl_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int errors;
	int pending;
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_ask  = 0;
	int hold_left = 0;

	always #2 clk = ~clk;

	indexed_shift_list_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	isl_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	// hold off for a requested stretch, else stall at random
	always @(posedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic req_t make_req(input logic [2:0] cmd, input int pos, input logic [31:0] d);
		req_t r;
		r.command  = cmd;
		r.position = 5'(pos);
		r.data_in  = d;
		return r;
	endfunction

	function automatic req_t random_req(input bit grow);
		req_t        r;
		int unsigned roll;
		roll       = $urandom_range(99);
		r.data_in  = $urandom;
		r.position = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
		if (roll < 3) r.command = 3'($urandom_range(7, 5));
		else if (grow) begin
			if (roll < 40) r.command = CMD_APPEND;
			else if (roll < 70) r.command = CMD_INSERT;
			else if (roll < 80) r.command = CMD_READ;
			else if (roll < 90) r.command = CMD_REMOVE;
			else r.command = CMD_POP;
		end else begin
			if (roll < 15) r.command = CMD_APPEND;
			else if (roll < 25) r.command = CMD_INSERT;
			else if (roll < 45) r.command = CMD_READ;
			else if (roll < 75) r.command = CMD_REMOVE;
			else r.command = CMD_POP;
		end
		return r;
	endfunction

	task automatic send_beat(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(make_req(CMD_POP, 0, 32'h0));
		send_beat(make_req(CMD_READ, 0, 32'h0));
		send_beat(make_req(CMD_INSERT, 1, 32'h1234_5678));
		send_beat(make_req(CMD_INSERT, 0, 32'hFFFF_FFFF));
		send_beat(make_req(CMD_APPEND, 0, 32'h0));
		send_beat(make_req(CMD_INSERT, 2, 32'hA5A5_A5A5));
		send_beat(make_req(CMD_INSERT, 0, 32'h5A5A_5A5A));
		send_beat(make_req(CMD_READ, 31, 32'h0));
		send_beat(make_req(3'd5, 16, 32'hFFFF_FFFF));
		send_beat(make_req(3'd7, 31, 32'h8000_0001));
		send_beat(make_req(CMD_REMOVE, 1, 32'h0));
		repeat (13) send_beat(make_req(CMD_APPEND, 0, $urandom));
		send_beat(make_req(CMD_APPEND, 0, 32'hDEAD_BEEF));
		send_beat(make_req(CMD_INSERT, 16, 32'hDEAD_BEEF));
		send_beat(make_req(CMD_INSERT, 17, 32'hDEAD_BEEF));
		send_beat(make_req(CMD_READ, 15, 32'h0));
		send_beat(make_req(CMD_REMOVE, 0, 32'h0));
		send_beat(make_req(CMD_REMOVE, 15, 32'h0));
		send_beat(make_req(CMD_POP, 0, 32'h0));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			for (int k = 0; k < 125; k++) begin
				if (ph == 0 && k == 60) hold_ask = 40;
				if (ph == 1 && k == 60) begin
					req_valid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end
				send_beat(random_req(((k / 20) % 2) == 0));
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### indexed_shift_list_core.f
+incdir+hdl
hdl/isl_pkg.sv
hdl/isl_front.sv
hdl/isl_back.sv
hdl/indexed_shift_list_core.sv
tb/isl_checker.sv
tb/tb.sv
